// File: rtl/fbfl_pkg.sv
// Shared constants, types and codes for the fixed block free list allocator.
package fbfl_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int HEAD_W = $clog2(NUM_BLOCKS + 1);
  localparam int STEP_W = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;

  localparam int BS_W = 13;
  localparam int COUNT_W = 9;
  localparam int SIZE_W = 16;
  localparam int REL_W = 24;
  localparam int BOFF_W = 20;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W = OUT_TDATA_W - BOFF_W - STATUS_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam int BS_RESET = 128;
  localparam int COUNT_RESET = 256;

  localparam int PROD_W = HEAD_W + BS_W;
  localparam int DIV_W = (REL_W > PROD_W) ? REL_W : PROD_W;

  typedef logic [HEAD_W-1:0] head_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [DIV_W-1:0] div_t;
  typedef logic [BOFF_W-1:0] boff_t;
  typedef logic [BS_W-1:0] bsize_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE  = 2'd0,
    REG_BLOCK_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_RD,
    S_FREE_LIM,
    S_FREE_CMP,
    S_FREE_DIV,
    S_FREE_PUSH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic  done;
    addr_t quotient;
  } div_res_t;

endpackage

// File: rtl/fbfl_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fbfl_div.sv
// Restoring divider that turns a byte offset into a block index, one quotient bit a cycle.
module fbfl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbfl_pkg::REL_W-1:0]  dividend,
  input  logic [fbfl_pkg::BS_W-1:0]   divisor,
  output fbfl_pkg::div_res_t          res
);

  logic                  busy;
  logic                  done;
  fbfl_pkg::step_t       step;
  fbfl_pkg::div_t        rem;
  fbfl_pkg::bsize_t      dsr;
  fbfl_pkg::addr_t       quot;
  fbfl_pkg::div_t        trial;

  // The caller guarantees dividend < NUM_BLOCKS * divisor, so the quotient fits ADDR_W bits.
  assign trial = fbfl_pkg::div_t'(dsr) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= fbfl_pkg::div_t'(dividend);
      dsr  <= divisor;
      quot <= '0;
      step <= fbfl_pkg::step_t'(fbfl_pkg::ADDR_W - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  assign res.done     = done;
  assign res.quotient = quot;

endmodule

// File: rtl/fixed_block_free_list_allocator.sv
// Allocate: size and head are checked, then the head's link entry is read; a failure skips the read.
// Free: the offset is checked against the pool, then divided by the bit-serial offset divider into a
// block index that is pushed. One request is worked at a time; the next is taken the cycle after the
// result moves to the output register, so it can start while that result waits.
// Reset sets block size 128, block count 256, head 0 and clears the per-entry valid bits,
// so every unwritten link entry reads as its own index plus one; no clearing pass.
module fixed_block_free_list_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [15:0] request_size, [39:16] release_offset
  input  logic [fbfl_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] operation
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [21:2] block_offset, [23:22] zero
  output logic [fbfl_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fbfl_pkg::state_e   state;
  fbfl_pkg::state_e   state_next;

  fbfl_pkg::bsize_t   blk_bytes;
  fbfl_pkg::count_t   block_count;
  fbfl_pkg::head_t    active_count;
  fbfl_pkg::head_t    free_head;
  logic [fbfl_pkg::NUM_BLOCKS-1:0] link_valid;

  logic                              op;
  logic [fbfl_pkg::SIZE_W-1:0]       req_size;
  logic [fbfl_pkg::REL_W-1:0]        rel_offset;
  fbfl_pkg::prod_t                   limit;
  fbfl_pkg::prod_t                   prod;
  fbfl_pkg::status_e                 res_status;
  fbfl_pkg::boff_t                   res_offset;

  logic                              out_valid;
  fbfl_pkg::status_e                 out_status;
  fbfl_pkg::boff_t                   out_offset;

  logic                              in_take;
  logic                              mem_re;
  logic                              mem_we;
  logic                              div_start;
  logic                              out_load;
  logic                              size_bad;
  logic                              head_out;
  logic                              off_bad;
  fbfl_pkg::head_t                   link_rdata;
  fbfl_pkg::head_t                   link_next;
  fbfl_pkg::div_res_t                div_res;

  assign in_take   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (int'(block_count) > fbfl_pkg::NUM_BLOCKS) begin
      active_count = fbfl_pkg::head_t'(fbfl_pkg::NUM_BLOCKS);
    end else begin
      active_count = fbfl_pkg::head_t'(block_count);
    end
  end

  assign size_bad = 32'(req_size) > 32'(blk_bytes);
  assign head_out = free_head >= active_count;
  assign prod     = fbfl_pkg::prod_t'(free_head) * fbfl_pkg::prod_t'(blk_bytes);
  assign off_bad  = fbfl_pkg::div_t'(rel_offset) >= fbfl_pkg::div_t'(limit);

  // Entries never written since reset still hold the initial chain.
  assign link_next = link_valid[free_head[fbfl_pkg::ADDR_W-1:0]] ? link_rdata
                                                                  : free_head + 1'b1;

  fbfl_ram #(
    .WIDTH(fbfl_pkg::HEAD_W),
    .DEPTH(fbfl_pkg::NUM_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(div_res.quotient),
    .wdata(free_head),
    .re   (mem_re),
    .raddr(free_head[fbfl_pkg::ADDR_W-1:0]),
    .rdata(link_rdata)
  );

  fbfl_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(rel_offset),
    .divisor (blk_bytes),
    .res     (div_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      fbfl_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = s_tuser ? fbfl_pkg::S_FREE_LIM : fbfl_pkg::S_ALLOC;
        end
      end
      fbfl_pkg::S_ALLOC: begin
        if (size_bad || head_out) begin
          state_next = fbfl_pkg::S_RESP;
        end else begin
          state_next = fbfl_pkg::S_ALLOC_RD;
        end
      end
      fbfl_pkg::S_ALLOC_RD: state_next = fbfl_pkg::S_RESP;
      fbfl_pkg::S_FREE_LIM: begin
        state_next = (blk_bytes == '0) ? fbfl_pkg::S_RESP : fbfl_pkg::S_FREE_CMP;
      end
      fbfl_pkg::S_FREE_CMP: begin
        state_next = off_bad ? fbfl_pkg::S_RESP : fbfl_pkg::S_FREE_DIV;
      end
      fbfl_pkg::S_FREE_DIV: begin
        if (div_res.done) begin
          state_next = fbfl_pkg::S_FREE_PUSH;
        end
      end
      fbfl_pkg::S_FREE_PUSH: state_next = fbfl_pkg::S_RESP;
      fbfl_pkg::S_RESP: begin
        if (!out_valid || m_tready) begin
          state_next = fbfl_pkg::S_IDLE;
        end
      end
      default: state_next = fbfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      fbfl_pkg::S_IDLE:      s_tready = 1'b1;
      fbfl_pkg::S_ALLOC:     mem_re = !size_bad && !head_out;
      fbfl_pkg::S_FREE_CMP:  div_start = !off_bad;
      fbfl_pkg::S_FREE_PUSH: mem_we = 1'b1;
      fbfl_pkg::S_RESP:      out_load = !out_valid || m_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes   <= fbfl_pkg::bsize_t'(fbfl_pkg::BS_RESET);
      block_count <= fbfl_pkg::count_t'(fbfl_pkg::COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbfl_pkg::REG_BLOCK_SIZE:  blk_bytes <= cfg_data[fbfl_pkg::BS_W-1:0];
        fbfl_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[fbfl_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      link_valid <= '0;
    end else if (state == fbfl_pkg::S_ALLOC_RD) begin
      free_head <= link_next;
    end else if (mem_we) begin
      free_head                    <= fbfl_pkg::head_t'(div_res.quotient);
      link_valid[div_res.quotient] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op         <= s_tuser;
      req_size   <= s_tdata[fbfl_pkg::SIZE_W-1:0];
      rel_offset <= s_tdata[fbfl_pkg::SIZE_W +: fbfl_pkg::REL_W];
      res_status <= fbfl_pkg::ST_OK;
      res_offset <= '0;
    end
    case (state)
      fbfl_pkg::S_ALLOC: begin
        if (size_bad) begin
          res_status <= fbfl_pkg::ST_TOO_LARGE;
        end else if (head_out) begin
          res_status <= fbfl_pkg::ST_EMPTY;
        end else begin
          res_offset <= fbfl_pkg::boff_t'(prod);
        end
      end
      fbfl_pkg::S_FREE_LIM: begin
        limit <= fbfl_pkg::prod_t'(active_count) * fbfl_pkg::prod_t'(blk_bytes);
        if (blk_bytes == '0) begin
          res_status <= fbfl_pkg::ST_BAD_FREE;
        end
      end
      fbfl_pkg::S_FREE_CMP: begin
        if (off_bad) begin
          res_status <= fbfl_pkg::ST_BAD_FREE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{fbfl_pkg::OUT_PAD_W{1'b0}}, out_offset, out_status};

  // A free only reaches the push step with an index inside the pool.
  a_push_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == fbfl_pkg::S_FREE_PUSH) |-> (fbfl_pkg::head_t'(div_res.quotient) < active_count))
    else $error("freed block index outside the pool");

  // Only a successful allocate carries a nonzero offset.
  a_offset_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != fbfl_pkg::ST_OK) |-> (out_offset == '0))
    else $error("failed request returned a block offset");

  // The allocate path only reads a link entry for a head inside the pool.
  a_read_in_pool: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (free_head < active_count && op == 1'b0))
    else $error("link read with head outside the pool");

  // A taken request blocks the input until its result has moved to the output register.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !s_tready)
    else $error("second request taken while one is in flight");

endmodule

// File: tb/sv/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for the fixed block free list allocator, with its own free list predictor.
module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct {
    op_e             op;
    logic [SIZE_W-1:0] size;
    logic [REL_W-1:0]  offset;
  } request_t;

  typedef struct {
    status_e status;
    boff_t   offset;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fixed_block_free_list_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: the free list and the two registers.
  bsize_t blk_size = bsize_t'(BS_RESET);
  count_t blk_count = count_t'(COUNT_RESET);
  head_t  list_head = '0;
  head_t  list_next [NUM_BLOCKS];

  request_t requests_pending[$];
  reply_t   replies_due[$];
  request_t offered;
  bit       offering = 1'b0;
  bit       offer_taken = 1'b0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned requests_taken = 0;
  int unsigned settings_used = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned pool_limit();
    return (blk_count > NUM_BLOCKS) ? NUM_BLOCKS : blk_count;
  endfunction

  // Works one request against the predicted free list and returns its reply.
  function automatic reply_t serve_request(request_t r);
    reply_t y;
    int unsigned limit;
    int unsigned idx;
    int unsigned prod;
    y.status = ST_OK;
    y.offset = '0;
    limit = pool_limit();
    if (r.op == OP_ALLOC) begin
      if (r.size > blk_size) begin
        y.status = ST_TOO_LARGE;
      end else if (list_head >= limit) begin
        y.status = ST_EMPTY;
      end else begin
        prod = 32'(list_head) * 32'(blk_size);
        y.offset = boff_t'(prod);
        list_head = list_next[list_head[ADDR_W-1:0]];
      end
    end else if (blk_size == 0) begin
      y.status = ST_BAD_FREE;
    end else begin
      idx = 32'(r.offset) / 32'(blk_size);
      if (idx >= limit) begin
        y.status = ST_BAD_FREE;
      end else begin
        list_next[idx] = list_head;
        list_head = head_t'(idx);
      end
    end
    return y;
  endfunction

  function automatic request_t random_request(int unsigned alloc_pct);
    request_t r;
    int unsigned roll;
    int unsigned limit;
    int unsigned idx;
    r.size = SIZE_W'($urandom);
    r.offset = REL_W'($urandom);
    limit = pool_limit();
    roll = $urandom_range(99);
    if ($urandom_range(99) < alloc_pct) begin
      r.op = OP_ALLOC;
      if (roll < 85)
        r.size = SIZE_W'($urandom_range(blk_size));
      else if (roll < 93)
        r.size = SIZE_W'($urandom_range(65535, 32'(blk_size) + 1));
    end else begin
      r.op = OP_FREE;
      // Mostly offsets inside the pool, so that the list keeps moving.
      if (roll < 75 && blk_size != 0 && limit != 0) begin
        idx = $urandom_range(limit - 1);
        r.offset = REL_W'(idx * blk_size + $urandom_range(32'(blk_size) - 1));
      end else if (roll < 88) begin
        r.offset = REL_W'(limit * blk_size + $urandom_range(32'(blk_size) * 4));
      end
    end
    return r;
  endfunction

  task automatic queue_alloc(input int unsigned size);
    request_t r;
    r.op = OP_ALLOC;
    r.size = SIZE_W'(size);
    r.offset = REL_W'($urandom);
    requests_pending.push_back(r);
  endtask

  task automatic queue_free(input int unsigned offset);
    request_t r;
    r.op = OP_FREE;
    r.size = SIZE_W'($urandom);
    r.offset = REL_W'(offset);
    requests_pending.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLOCK_SIZE)
      blk_size = bsize_t'(value);
    else if (idx == REG_BLOCK_COUNT)
      blk_count = count_t'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued request is sent and every reply is in, then lets the block settle.
  task automatic wait_drained();
    while (requests_pending.size() != 0 || offering || replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned bsize, input int unsigned bcount,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned n_items, input int unsigned alloc_pct);
    write_reg(REG_BLOCK_SIZE, bsize);
    write_reg(REG_BLOCK_COUNT, bcount);
    settings_used++;
    idle_pct = idle;
    stall_pct = stall;
    repeat (n_items) requests_pending.push_back(random_request(alloc_pct));
    wait_drained();
  endtask

  // Sender: a request stays offered until it is taken.
  always @(negedge clk) begin
    if (offer_taken) begin
      offering = 1'b0;
      offer_taken = 1'b0;
    end
    if (!rst && !offering && requests_pending.size() != 0 &&
        $urandom_range(99) >= idle_pct) begin
      offered = requests_pending.pop_front();
      offering = 1'b1;
    end
    s_tvalid <= offering;
    s_tuser <= offering ? offered.op : 1'b0;
    s_tdata <= offering ? {offered.offset, offered.size} : '0;
  end

  // Receiver, with its own count of a long hold-off.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    request_t got_req;
    status_e got_status;
    boff_t got_offset;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_status = status_e'(m_tdata[STATUS_W-1:0]);
        got_offset = m_tdata[STATUS_W +: BOFF_W];
        status_seen[got_status]++;
        if (replies_due.size() == 0) begin
          $error("unexpected reply: status %0d, block_offset 0x%0h", got_status, got_offset);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fail_count++;
          end
          if (got_offset !== want.offset) begin
            $error("block_offset: expected 0x%0h, got 0x%0h", want.offset, got_offset);
            fail_count++;
          end
          if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
            $error("pad: expected 0, got %0d", m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        got_req.op = op_e'(s_tuser);
        got_req.size = s_tdata[SIZE_W-1:0];
        got_req.offset = s_tdata[SIZE_W +: REL_W];
        replies_due.push_back(serve_request(got_req));
        offer_taken = 1'b1;
        requests_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) list_next[i] = head_t'(i + 1);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Reset settings: 128-byte blocks, full pool.
    queue_alloc(0);
    queue_alloc(128);
    queue_alloc(129);
    queue_alloc(65535);
    queue_free(128 + 5);       // unaligned offset frees block 1
    queue_alloc(1);
    queue_free(0);
    queue_free(24'hFFFFFF);
    queue_free(256 * 128);     // first offset past the pool
    queue_free(256 * 128 - 1);
    queue_alloc(64);
    wait_drained();

    // Two one-byte blocks: run the pool dry; the size check wins over empty.
    write_reg(REG_BLOCK_SIZE, 1);
    write_reg(REG_BLOCK_COUNT, 2);
    queue_alloc(1);
    queue_alloc(0);
    queue_alloc(1);
    queue_alloc(2);
    queue_free(1);
    queue_free(2);
    wait_drained();

    // Zero block size.
    write_reg(REG_BLOCK_SIZE, 0);
    queue_alloc(0);
    queue_alloc(1);
    queue_free(0);
    wait_drained();

    // All-ones writes: widest block, count above the store depth; spare index ignored.
    write_reg(REG_BLOCK_SIZE, 13'h1FFF);
    write_reg(REG_BLOCK_COUNT, 13'h1FFF);
    write_reg(REG_SPARE, 13'h0AAA);
    settings_used += 3;
    queue_alloc(8191);
    queue_alloc(8192);
    queue_alloc(100);
    wait_drained();

    run_phase(1, 1, 0, 0, 100, 60);
    run_phase(4096, 256, 56, 0, 150, 70);
    run_phase(13'h1FFF, 13'h1FFF, 0, 56, 150, 65);
    run_phase(0, 8, 26, 26, 60, 50);
    run_phase(64, 0, 0, 0, 30, 50);

    // Long receiver hold-off while requests keep coming, so the input backs up.
    hold_request = 300;
    run_phase(32, 16, 0, 0, 40, 60);

    for (int k = 0; k < 6; k++) begin
      case (k % 3)
        0: run_phase($urandom_range(4096, 1), $urandom_range(16, 1),
                     (k % 2) ? 56 : 0, (k % 2) ? 0 : 56, 130, 55);
        1: run_phase($urandom_range(64, 1), 256, 26, 26, 130, 60);
        default: run_phase($urandom_range(4096, 1), $urandom_range(256, 1),
                           (k < 3) ? 0 : 56, (k < 3) ? 56 : 26, 130, 50);
      endcase
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    $display("Ran %0d requests under %0d register settings in %0d cycles.",
             requests_taken, settings_used, cycle_count);
    $display("Replies seen: %0d ok, %0d too large, %0d pool empty, %0d bad free.",
             status_seen[ST_OK], status_seen[ST_TOO_LARGE], status_seen[ST_EMPTY],
             status_seen[ST_BAD_FREE]);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/fbfl_pkg.sv
rtl/fbfl_ram.sv
rtl/fbfl_div.sv
rtl/fixed_block_free_list_allocator.sv
tb/sv/fixed_block_free_list_allocator_tb.sv
